[rtl/atc_pkg.sv]
// atc_pkg: shared constants and the pipeline word type of the altitude thrust controller.
// No dependencies.
package atc_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 31;

	localparam logic [CFG_IDX_W-1:0] REG_MASS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALT_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VEL_GAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_UP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DOWN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_THR = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_THR = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_COS = 3'd7;

	localparam logic [30:0] RST_MASS = 31'd65536;
	localparam logic [30:0] RST_ALT_GAIN = 31'd65536;
	localparam logic [30:0] RST_VEL_GAIN = 31'd32768;
	localparam logic [30:0] RST_MAX_UP = 31'd327680;
	localparam logic [30:0] RST_MAX_DOWN = 31'd327680;
	localparam logic [30:0] RST_MIN_THR = 31'd0;
	localparam logic [30:0] RST_MAX_THR = 31'd1310720;
	localparam logic [16:0] RST_MIN_COS = 17'd32768;

	localparam logic [30:0] GRAVITY_DEF = 31'd642689;

	// stage plan
	localparam int ST_PROD = 2;      // gain products
	localparam int ST_ACC = 3;       // accel sum and clamp
	localparam int ST_FMUL = 4;      // mass product
	localparam int ST_FORCE = 5;     // force scaling
	localparam int ST_CDIV_LO = 2;   // cosine quotient bits 16..0
	localparam int ST_CDIV_HI = 18;
	localparam int ST_TINIT = 19;    // cosine clamp, thrust divide setup
	localparam int ST_TDIV_LO = 20;  // thrust quotient bits 30..0
	localparam int ST_TDIV_HI = 50;
	localparam int NS = 51;          // final clamp, output register

	typedef struct packed {
		logic               rej;
		logic               sat;
		logic signed [32:0] err_a;
		logic signed [32:0] err_r;
		logic signed [31:0] ff;
		logic [32:0]        den;
		logic [48:0]        crem;
		logic [16:0]        cq;
		logic signed [64:0] p1;
		logic signed [64:0] p2;
		logic signed [31:0] acc;
		logic signed [32:0] ga;
		logic signed [64:0] prod;
		logic signed [48:0] frc;
		logic [16:0]        cosq;
		logic               neg;
		logic               ovf;
		logic [47:0]        trem;
		logic [30:0]        tq;
		logic [30:0]        thr;
	} pipe_t;

endpackage

[rtl/altitude_thrust_controller.sv]
// altitude_thrust_controller: PD plus feedforward altitude control with tilt compensation.
// Depends on atc_pkg.
//
//  channel  signals                         direction  word
//  req      req_valid/req_ready + 9 fields  in         sensor and target sample
//  rsp      rsp_valid/rsp_ready + 4 fields  out        thrust command
//  cfg      cfg_we, cfg_index, cfg_data     in         register write, no handshake
//
// 51 register stages, one word per cycle while rsp_ready keeps the last stage moving.
// The depth is set by the restoring dividers: 17 quotient steps for the tilt
// cosine, 31 for the thrust, one bit per stage.
// Each stage holds while full and its successor holds; empty stages fill.
// arst_n clears stage valid bits and loads register defaults.
module altitude_thrust_controller
	import atc_pkg::*;
#(
	parameter logic [30:0] GRAVITY_Q16 = GRAVITY_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  logic signed [31:0]   target_altitude,
	input  logic signed [31:0]   target_climb_rate,
	input  logic signed [31:0]   feedforward_accel,
	input  logic signed [31:0]   measured_altitude,
	input  logic signed [31:0]   measured_climb_rate,
	input  logic signed [15:0]   quat_w,
	input  logic signed [15:0]   quat_x,
	input  logic signed [15:0]   quat_y,
	input  logic signed [15:0]   quat_z,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output logic                 result_valid,
	output logic                 saturated,
	output logic signed [31:0]   commanded_accel,
	output logic [30:0]          total_thrust
);

	logic [30:0] mass_q, alt_gain_q, vel_gain_q, max_up_q, max_down_q, min_thr_q, max_thr_q;
	logic [16:0] min_cos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q <= RST_MASS;
			alt_gain_q <= RST_ALT_GAIN;
			vel_gain_q <= RST_VEL_GAIN;
			max_up_q <= RST_MAX_UP;
			max_down_q <= RST_MAX_DOWN;
			min_thr_q <= RST_MIN_THR;
			max_thr_q <= RST_MAX_THR;
			min_cos_q <= RST_MIN_COS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MASS: mass_q <= cfg_data;
				REG_ALT_GAIN: alt_gain_q <= cfg_data;
				REG_VEL_GAIN: vel_gain_q <= cfg_data;
				REG_MAX_UP: max_up_q <= cfg_data;
				REG_MAX_DOWN: max_down_q <= cfg_data;
				REG_MIN_THR: min_thr_q <= cfg_data;
				REG_MAX_THR: max_thr_q <= cfg_data;
				REG_MIN_COS: min_cos_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	pipe_t       data_s [1:NS];
	pipe_t       nxt_d [1:NS];
	logic [NS:1] vld_s;
	logic [NS:1] en;

	// stage 1: errors and quaternion terms
	logic signed [31:0] w2, x2, y2, z2;
	logic signed [33:0] num;
	always_comb begin
		w2 = quat_w * quat_w;
		x2 = quat_x * quat_x;
		y2 = quat_y * quat_y;
		z2 = quat_z * quat_z;
		num = 34'(w2) + 34'(z2) - 34'(x2) - 34'(y2);
		nxt_d[1] = '0;
		nxt_d[1].rej = (num <= 34'sd0);
		nxt_d[1].err_a = 33'(target_altitude) - 33'(measured_altitude);
		nxt_d[1].err_r = 33'(target_climb_rate) - 33'(measured_climb_rate);
		nxt_d[1].ff = feedforward_accel;
		nxt_d[1].den = 33'(w2[30:0]) + 33'(x2[30:0]) + 33'(y2[30:0]) + 33'(z2[30:0]);
		nxt_d[1].crem = {1'b0, num[31:0], 16'b0};
	end

	for (genvar k = 2; k <= NS; k++) begin : g_stage
		localparam int CB = (k >= ST_CDIV_LO && k <= ST_CDIV_HI) ? ST_CDIV_HI - k : 0;
		localparam int TB = (k >= ST_TDIV_LO && k <= ST_TDIV_HI) ? ST_TDIV_HI - k : 0;
		pipe_t              d;
		logic [48:0]        cdv;
		logic [47:0]        tdv;
		logic signed [50:0] raw, up, down, clp;
		logic [16:0]        mincos;
		logic [63:0]        dvd;
		always_comb begin
			d = data_s[k-1];
			cdv = 49'(d.den) << CB;
			tdv = 48'(d.cosq) << TB;
			raw = 51'(d.p1 >>> 16) + 51'(d.p2 >>> 16) + 51'(d.ff);
			up = 51'($signed({1'b0, max_up_q}));
			down = -51'($signed({1'b0, max_down_q}));
			mincos = (min_cos_q == 17'd0) ? 17'd1 : min_cos_q;
			dvd = {d.frc[47:0], 16'b0};
			clp = raw;
			if (k >= ST_CDIV_LO && k <= ST_CDIV_HI) begin
				if (d.crem >= cdv) begin
					d.crem = d.crem - cdv;
					d.cq[CB] = 1'b1;
				end
			end
			if (k == ST_PROD) begin
				d.p1 = $signed({1'b0, alt_gain_q}) * d.err_a;
				d.p2 = $signed({1'b0, vel_gain_q}) * d.err_r;
			end
			if (k == ST_ACC) begin
				priority if (raw > up) clp = up;
				else if (raw < down) clp = down;
				else clp = raw;
				d.sat = d.sat | (clp != raw);
				d.acc = 32'(clp);
				d.ga = 33'($signed({2'b0, GRAVITY_Q16})) + 33'(d.acc);
			end
			if (k == ST_FMUL)
				d.prod = $signed({1'b0, mass_q}) * d.ga;
			if (k == ST_FORCE)
				d.frc = $signed(d.prod[64:16]);
			if (k == ST_TINIT) begin
				if (d.cq < mincos) begin
					d.cosq = mincos;
					d.sat = 1'b1;
				end else begin
					d.cosq = d.cq;
				end
				d.neg = d.frc[48];
				d.ovf = dvd >= {16'b0, d.cosq, 31'b0};
				d.trem = dvd[47:0];
			end
			if (k >= ST_TDIV_LO && k <= ST_TDIV_HI) begin
				if (d.trem >= tdv) begin
					d.trem = d.trem - tdv;
					d.tq[TB] = 1'b1;
				end
			end
			if (k == NS) begin
				priority if (d.neg) begin
					d.thr = min_thr_q;
					d.sat = 1'b1;
				end else if (d.ovf) begin
					d.thr = max_thr_q;
					d.sat = 1'b1;
				end else if (d.tq < min_thr_q) begin
					d.thr = min_thr_q;
					d.sat = 1'b1;
				end else if (d.tq > max_thr_q) begin
					d.thr = max_thr_q;
					d.sat = 1'b1;
				end else begin
					d.thr = d.tq;
				end
				if (d.rej) begin
					d.sat = 1'b1;
					d.acc = '0;
					d.thr = '0;
				end
			end
			nxt_d[k] = d;
		end
	end

	always_comb begin
		en[NS] = !vld_s[NS] || rsp_ready;
		for (int i = NS - 1; i >= 1; i--)
			en[i] = !vld_s[i] || en[i+1];
	end

	for (genvar k = 1; k <= NS; k++) begin : g_reg
		logic vin;
		if (k == 1) begin : g_first
			assign vin = req_valid;
		end else begin : g_rest
			assign vin = vld_s[k-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (en[k])
				vld_s[k] <= vin;
		end
		always_ff @(posedge clk) begin
			if (en[k] && vin)
				data_s[k] <= nxt_d[k];
		end
	end

	assign req_ready = en[1];
	assign rsp_valid = vld_s[NS];
	assign result_valid = !data_s[NS].rej;
	assign saturated = data_s[NS].sat;
	assign commanded_accel = data_s[NS].acc;
	assign total_thrust = data_s[NS].thr;

	a_rej_sat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !result_valid |-> saturated)
		else $error("rejected word without saturated");
	a_rej_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !result_valid |-> commanded_accel == 32'sd0 && total_thrust == 31'd0)
		else $error("rejected word carries values");
	a_thr_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && result_valid && !saturated
		|-> total_thrust >= min_thr_q && total_thrust <= max_thr_q)
		else $error("unsaturated thrust outside limits");
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> vld_s[1])
		else $error("accepted word lost at entry");

endmodule

[tb/sv/tb_top.sv]
// tb_top: self-checking testbench of altitude_thrust_controller.
// Directed table, then random phases over several register settings, checked against
// a fixed-point predictor of the control law; depends on atc_pkg and the RTL only.
module tb_top;
	import atc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GRAV = 642689;
	localparam int FLUSH_CYC = 64;
	localparam int STALL_LIMIT = 5000;

	typedef struct {
		logic signed [31:0] t_alt, t_rate, ff, m_alt, m_rate;
		logic signed [15:0] qw, qx, qy, qz;
	} sample_t;

	typedef struct packed {
		logic        ok;
		logic        sat;
		logic [31:0] acc;
		logic [30:0] thr;
	} cmd_t;

	typedef struct {
		sample_t s;
		bit      typed;
		cmd_t    want;
	} row_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic req_valid, req_ready, rsp_valid, rsp_ready;
	logic signed [31:0] target_altitude, target_climb_rate, feedforward_accel;
	logic signed [31:0] measured_altitude, measured_climb_rate;
	logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
	logic result_valid, saturated;
	logic signed [31:0] commanded_accel;
	logic [30:0] total_thrust;

	altitude_thrust_controller dut (.*);

	longint mass, kp, kd, up_lim, dn_lim, thr_lo, thr_hi, cos_min;
	cmd_t pending_cmds[$];
	row_t rows[$];
	int errors = 0;
	int idle_cyc = 0;
	bit hold_req = 0;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic longint fdiv(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) < 0) q -= 1;
		return q;
	endfunction

	function automatic cmd_t thrust_cmd(sample_t s);
		cmd_t c;
		longint w, x, y, z, den, num, cq, mc, raw, acc, frc, rt, thr;
		bit sat;
		w = s.qw; x = s.qx; y = s.qy; z = s.qz;
		den = w*w + x*x + y*y + z*z;
		num = w*w - x*x - y*y + z*z;
		c = '0;
		if (den == 0 || num <= 0) begin
			c.sat = 1;
			return c;
		end
		sat = 0;
		cq = fdiv(num * 65536, den);
		raw = fdiv(kp * (longint'(s.t_alt) - longint'(s.m_alt)), 65536)
			+ fdiv(kd * (longint'(s.t_rate) - longint'(s.m_rate)), 65536) + longint'(s.ff);
		acc = raw;
		if (acc > up_lim) acc = up_lim;
		else if (acc < -dn_lim) acc = -dn_lim;
		if (acc != raw) sat = 1;
		frc = fdiv(mass * (GRAV + acc), 65536);
		mc = (cos_min < 1) ? 1 : cos_min;
		if (cq < mc) begin
			cq = mc;
			sat = 1;
		end
		rt = fdiv(frc * 65536, cq);
		thr = rt;
		if (thr < thr_lo) thr = thr_lo;
		else if (thr > thr_hi) thr = thr_hi;
		if (thr != rt) sat = 1;
		c.ok = 1;
		c.sat = sat;
		c.acc = acc[31:0];
		c.thr = thr[30:0];
		return c;
	endfunction

	task automatic write_regs(longint v[8]);
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1;
			cfg_index <= i[CFG_IDX_W-1:0];
			cfg_data <= v[i][CFG_DATA_W-1:0];
			@(posedge clk);
		end
		cfg_we <= 0;
		mass = v[REG_MASS] & 64'h7fffffff;
		kp = v[REG_ALT_GAIN] & 64'h7fffffff;
		kd = v[REG_VEL_GAIN] & 64'h7fffffff;
		up_lim = v[REG_MAX_UP] & 64'h7fffffff;
		dn_lim = v[REG_MAX_DOWN] & 64'h7fffffff;
		thr_lo = v[REG_MIN_THR] & 64'h7fffffff;
		thr_hi = v[REG_MAX_THR] & 64'h7fffffff;
		cos_min = v[REG_MIN_COS] & 64'h1ffff;
	endtask

	task automatic drain;
		wait (pending_cmds.size() == 0);
		repeat (FLUSH_CYC) @(posedge clk);
	endtask

	// one word on the request channel; valid stays up for a following word
	task automatic send(sample_t s, bit typed, cmd_t want);
		req_valid <= 1;
		target_altitude <= s.t_alt;
		target_climb_rate <= s.t_rate;
		feedforward_accel <= s.ff;
		measured_altitude <= s.m_alt;
		measured_climb_rate <= s.m_rate;
		quat_w <= s.qw;
		quat_x <= s.qx;
		quat_y <= s.qy;
		quat_z <= s.qz;
		do @(posedge clk); while (!req_ready);
		pending_cmds.push_back(typed ? want : thrust_cmd(s));
	endtask

	function automatic logic [31:0] rnd_sig();
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return $signed($urandom_range(0, 2000000)) - 1000000;
			2: return $signed($urandom_range(0, 40000)) - 20000;
			3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: return $signed($urandom_range(0, 200000)) - 100000;
		endcase
	endfunction

	function automatic sample_t rnd_sample();
		sample_t s;
		int mag;
		s.t_alt = rnd_sig();
		s.m_alt = ($urandom_range(0, 2) == 0) ? rnd_sig() : s.t_alt + $signed($urandom_range(0, 400000)) - 200000;
		s.t_rate = rnd_sig();
		s.m_rate = ($urandom_range(0, 2) == 0) ? rnd_sig() : s.t_rate + $signed($urandom_range(0, 200000)) - 100000;
		s.ff = ($urandom_range(0, 3) == 0) ? rnd_sig() : $signed($urandom_range(0, 800000)) - 400000;
		case ($urandom_range(0, 9))
			0: begin
				s.qw = 16'($urandom()); s.qx = 16'($urandom());
				s.qy = 16'($urandom()); s.qz = 16'($urandom());
			end
			1: begin
				s.qw = '0; s.qx = '0; s.qy = '0; s.qz = '0;
			end
			2: begin
				s.qw = 16'($urandom_range(0, 200)); s.qx = 16'($urandom());
				s.qy = 16'($urandom_range(0, 3000));
				s.qz = '0;
			end
			default: begin
				mag = $urandom_range(0, 1) ? 32767 : $urandom_range(1, 300);
				s.qw = 16'($urandom_range(0, 1) ? mag : -mag);
				s.qx = 16'($signed($urandom_range(0, mag)) - mag / 2);
				s.qy = 16'($signed($urandom_range(0, mag)) - mag / 2);
				s.qz = 16'($signed($urandom_range(0, mag / 4)) - mag / 8);
				if ($urandom_range(0, 5) == 0) s.qw = -16'sd32768;
			end
		endcase
		return s;
	endfunction

	function automatic sample_t mk(int ta, int ma, int tr, int mr, int ff,
		int w, int x, int y, int z);
		sample_t s;
		s.t_alt = ta; s.m_alt = ma; s.t_rate = tr; s.m_rate = mr; s.ff = ff;
		s.qw = 16'(w); s.qx = 16'(x); s.qy = 16'(y); s.qz = 16'(z);
		return s;
	endfunction

	task automatic add_row(sample_t s, bit typed, cmd_t want);
		row_t r;
		r.s = s; r.typed = typed; r.want = want;
		rows.push_back(r);
	endtask

	task automatic run_random(int n);
		int burst;
		while (n > 0) begin
			burst = $urandom_range(1, 24);
			for (int i = 0; i < burst && n > 0; i++, n--)
				send(rnd_sample(), 0, '0);
			if ($urandom_range(0, 3) != 0) begin
				req_valid <= 0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
		end
		req_valid <= 0;
	endtask

	// receiver: periodic stall pattern, random stretches, full-rate stretches, and a long hold on hold_req
	initial begin
		int mode, left, ph;
		rsp_ready = 0;
		ph = 0;
		forever begin
			mode = $urandom_range(0, 2);
			left = $urandom_range(20, 120);
			while (left > 0 && !hold_req) begin
				case (mode)
					0: rsp_ready <= 1;
					1: rsp_ready <= ($urandom_range(0, 2) != 0);
					default: rsp_ready <= (ph % 5 < 2);
				endcase
				ph++;
				left--;
				@(posedge clk);
			end
			if (hold_req) begin
				rsp_ready <= 0;
				repeat (400) @(posedge clk);
				hold_req = 0;
			end
		end
	end

	always @(posedge clk) begin
		cmd_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_cmds.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected word: valid=%0b sat=%0b acc=%0d thr=%0d",
					result_valid, saturated, commanded_accel, total_thrust);
			end else begin
				want = pending_cmds.pop_front();
				if (result_valid !== want.ok || saturated !== want.sat ||
					commanded_accel !== want.acc || total_thrust !== want.thr) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp valid=%0b sat=%0b acc=%0d thr=%0d, got %0b %0b %0d %0d",
							want.ok, want.sat, $signed(want.acc), want.thr, result_valid,
							saturated, commanded_accel, total_thrust);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cyc <= 0;
		else idle_cyc <= idle_cyc + 1;
		if (idle_cyc >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		longint cfg[8];
		cmd_t rej, c;
		arst_n = 0;
		cfg_we = 0; cfg_index = '0; cfg_data = '0;
		req_valid = 0;
		target_altitude = 0; target_climb_rate = 0; feedforward_accel = 0;
		measured_altitude = 0; measured_climb_rate = 0;
		quat_w = 0; quat_x = 0; quat_y = 0; quat_z = 0;
		mass = 65536; kp = 65536; kd = 32768; up_lim = 327680; dn_lim = 327680;
		thr_lo = 0; thr_hi = 1310720; cos_min = 32768;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		rej = '0; rej.sat = 1;
		c = '0; c.ok = 1; c.thr = 31'd642689;
		add_row(mk(0, 0, 0, 0, 0, 16384, 0, 0, 0), 1, c);
		c.sat = 1; c.acc = 32'd327680; c.thr = 31'd970369;
		add_row(mk(0, 0, 0, 0, 10 << 16, 16384, 0, 0, 0), 1, c);
		add_row(mk(5, 5, 5, 5, 5, 0, 0, 0, 0), 1, rej);
		add_row(mk(0, 0, 0, 0, 0, 0, 1000, 0, 0), 1, rej);
		add_row(mk(0, 0, 0, 0, 0, 700, 700, 0, 0), 1, rej);
		add_row(mk(0, 0, 0, 0, 0, -32768, -32768, -32768, -32768), 1, rej);
		add_row(mk(0, 0, 0, 0, 0, 3, 2, 0, 0), 0, '0);
		add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, -32768), 0, '0);
		add_row(mk(0, 0, 0, 0, 0, 32767, 0, 32767, 32767), 0, '0);
		add_row(mk(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			-32768, 1, -1, 0), 0, '0);
		add_row(mk(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
			100, 10, -20, 30), 0, '0);
		add_row(mk(100000, 90000, -50000, 20000, -300000, 1000, -300, 200, -100), 0, '0);
		add_row(mk(0, 0, 0, 0, -(20 << 16), 16384, 0, 0, 0), 0, '0);
		add_row(mk(-1, 0, -1, 0, -1, 32767, 32767, 0, 32767), 0, '0);
		foreach (rows[i]) begin
			send(rows[i].s, rows[i].typed, rows[i].want);
			if (i % 4 == 3) begin
				req_valid <= 0;
				@(posedge clk);
			end
		end
		req_valid <= 0;
		drain();

		// moderate setting, with a long receiver hold while words keep coming
		cfg = '{98304, 32768, 16384, 655360, 393216, 65536, 2621440, 16384};
		write_regs(cfg);
		hold_req = 1;
		for (int i = 0; i < 150; i++) send(rnd_sample(), 0, '0);
		req_valid <= 0;
		run_random(30);
		drain();

		// largest values in every register but the minimum cosine, which is 65536
		cfg = '{31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff,
			31'h7fffffff, 31'h7fffffff, 65536};
		write_regs(cfg);
		run_random(140);
		drain();

		// smallest values, zero min cosine, zero mass
		cfg = '{0, 0, 0, 0, 0, 0, 1, 0};
		write_regs(cfg);
		run_random(100);
		drain();
		cfg = '{1, 1, 1, 1, 1, 0, 1, 131071};
		write_regs(cfg);
		run_random(60);
		drain();

		// inverted limits
		cfg = '{65536, 65536, 65536, 100000, -200000, 3000000, 1000000, 40000};
		cfg[REG_MAX_DOWN] = 200000;
		cfg[REG_MAX_UP] = 0;
		write_regs(cfg);
		run_random(120);
		drain();

		for (int p = 0; p < 3; p++) begin
			for (int i = 0; i < 8; i++)
				cfg[i] = $urandom_range(0, 1) ? $urandom_range(0, 31'h7fffffff) :
					$urandom_range(0, 4000000);
			cfg[REG_MIN_COS] = $urandom_range(0, 70000);
			cfg[REG_MASS] = $urandom_range(1, 400000);
			write_regs(cfg);
			run_random(85);
			drain();
		end

		if (errors == 0 && pending_cmds.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

[altitude_thrust_controller.f]
rtl/atc_pkg.sv
rtl/altitude_thrust_controller.sv
tb/sv/tb_top.sv
